### sv/mau_pkg.sv
// Package for the multi-width integer ALU.
// Holds the operation and status codes, the stage payload types and the width mask helper.
package mau_pkg;

    localparam int DATA_W = 64;
    localparam int PROD_W = 2 * DATA_W;
    localparam int HALF_W = DATA_W / 2;

    typedef enum logic [4:0] {
        ACT_ADD    = 5'd0,
        ACT_SUB    = 5'd1,
        ACT_MUL    = 5'd2,
        ACT_DIV    = 5'd3,
        ACT_MOD    = 5'd4,
        ACT_SHL    = 5'd5,
        ACT_SHR    = 5'd6,
        ACT_LT     = 5'd7,
        ACT_LE     = 5'd8,
        ACT_GT     = 5'd9,
        ACT_GE     = 5'd10,
        ACT_EQ     = 5'd11,
        ACT_NE     = 5'd12,
        ACT_AND    = 5'd13,
        ACT_OR     = 5'd14,
        ACT_XOR    = 5'd15,
        ACT_PLUS   = 5'd16,
        ACT_NEG    = 5'd17,
        ACT_BITNOT = 5'd18,
        ACT_LOGNOT = 5'd19
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVF   = 2'd1,
        ST_DIV0  = 2'd2,
        ST_SHIFT = 2'd3
    } t_status;

    localparam logic [DATA_W-1:0] MASK_B1 = 64'h0000_0000_0000_00FF;
    localparam logic [DATA_W-1:0] MASK_B2 = 64'h0000_0000_0000_FFFF;
    localparam logic [DATA_W-1:0] MASK_B4 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MASK_B8 = 64'hFFFF_FFFF_FFFF_FFFF;

    // Payload that travels beside the multiplier.
    typedef struct packed {
        t_action           act;
        logic              sg;
        logic              an;
        logic              bn;
        logic              b_zero;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] pre_r;
        t_status           pre_st;
    } t_mside;

    // Payload that travels beside the divider.
    typedef struct packed {
        t_action           act;
        logic              sg;
        logic              an;
        logic              bn;
        logic              b_zero;
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] pre_r;
        t_status           pre_st;
    } t_dside;

    function automatic logic [DATA_W-1:0] width_mask(input logic [1:0] wc);
        logic [DATA_W-1:0] m;
        case (wc)
            2'd0:    m = MASK_B1;
            2'd1:    m = MASK_B2;
            2'd2:    m = MASK_B4;
            default: m = MASK_B8;
        endcase
        return m;
    endfunction

endpackage

### sv/mau_if.sv
// Channel interfaces for the multi-width integer ALU.
// Depends on mau_pkg for the data width.
interface mau_in_if import mau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [4:0]        action;
    logic [DATA_W-1:0] operand_a;
    logic [DATA_W-1:0] operand_b;
    logic [1:0]        width_code;
    logic              signed_mode;

    modport source (output valid, action, operand_a, operand_b, width_code, signed_mode,
                    input ready);
    modport sink (input valid, action, operand_a, operand_b, width_code, signed_mode,
                  output ready);
endinterface

interface mau_out_if import mau_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] result;
    logic [1:0]        status;

    modport source (output valid, result, status, input ready);
    modport sink (input valid, result, status, output ready);
endinterface

### sv/mau_mul.sv
// Two-stage 64 by 64 unsigned multiplier built from four 32 by 32 partial products.
// Depends on mau_pkg; carries a side payload alongside the product.
module mau_mul import mau_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_ma,
    input  logic [DATA_W-1:0] i_mb,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [PROD_W-1:0] o_prod,
    output logic [SIDE_W-1:0] o_side
);
    logic [DATA_W-1:0] r_ll, r_m1, r_m2, r_hh;
    logic [SIDE_W-1:0] r_side1, r_side2;
    logic              r_v1, r_v2;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = {{DATA_W{1'b0}}, r_ll}
               + ({{DATA_W{1'b0}}, r_m1} << HALF_W)
               + ({{DATA_W{1'b0}}, r_m2} << HALF_W)
               + {r_hh, {DATA_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll    <= i_ma[HALF_W-1:0] * i_mb[HALF_W-1:0];
            r_m1    <= i_ma[DATA_W-1:HALF_W] * i_mb[HALF_W-1:0];
            r_m2    <= i_ma[HALF_W-1:0] * i_mb[DATA_W-1:HALF_W];
            r_hh    <= i_ma[DATA_W-1:HALF_W] * i_mb[DATA_W-1:HALF_W];
            r_side1 <= i_side;
            r_prod  <= n_prod;
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_side  = r_side2;
endmodule

### sv/mau_div.sv
// Pipelined restoring divider: one quotient bit per stage, 64 stages.
// Depends on mau_pkg; carries a side payload alongside each division.
module mau_div import mau_pkg::*; #(
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem,
    output logic [SIDE_W-1:0] o_side
);
    logic [DATA_W-1:0] r_rem  [DATA_W];
    logic [DATA_W-1:0] r_q    [DATA_W];
    logic [DATA_W-1:0] r_d    [DATA_W];
    logic [SIDE_W-1:0] r_side [DATA_W];
    logic [DATA_W-1:0] r_v;

    for (genvar k = 0; k < DATA_W; k++) begin : g_stage
        logic [DATA_W-1:0] p_rem, p_q, p_d;
        logic [SIDE_W-1:0] p_side;
        logic              p_v;
        logic [DATA_W:0]   trial;
        logic [DATA_W:0]   diff;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_q    = i_dividend;
            assign p_d    = i_divisor;
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_q    = r_q[k-1];
            assign p_d    = r_d[k-1];
            assign p_side = r_side[k-1];
            assign p_v    = r_v[k-1];
        end

        assign trial = {p_rem, p_q[DATA_W-1]};
        assign diff  = trial - {1'b0, p_d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!diff[DATA_W]) begin
                    r_rem[k] <= diff[DATA_W-1:0];
                end else begin
                    r_rem[k] <= trial[DATA_W-1:0];
                end
                r_q[k]    <= {p_q[DATA_W-2:0], ~diff[DATA_W]};
                r_d[k]    <= p_d;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[DATA_W-1];
    assign o_quot  = r_q[DATA_W-1];
    assign o_rem   = r_rem[DATA_W-1];
    assign o_side  = r_side[DATA_W-1];
endmodule

### sv/multi_width_integer_alu.sv
// Top level of the multi-width integer ALU.
// Depends on mau_pkg, the channel interfaces, mau_mul and mau_div.
// The ALU accepts one transaction per clock, unless the output stalls, through 69 register
// stages: one decode stage, two multiplier stages, one multiplier flag stage, 64 divider
// stages (one quotient bit each) and the output register. A result passes through these
// stages in order and waits in the output register until it is taken. The whole pipeline
// advances together whenever the output register is empty or being taken, so a stall at
// the output holds every stage in place and the input stays ready otherwise.
module multi_width_integer_alu import mau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mau_in_if.sink    i_in,
    mau_out_if.source o_out
);
    logic              en;
    t_action           act;
    logic [DATA_W-1:0] mask, sbit, a, b, sum, dif, xa, xb, shr_r, ma, mb, pre_r;
    logic              sg, an, bn, b_big;
    t_status           pre_st;
    logic [6:0]        bits;
    logic [5:0]        sh;

    t_mside            n_ms, r_ms, m_side;
    logic              r_dv, m_v;
    logic [PROD_W-1:0] m_prod;

    t_dside            n_ds, r_ds, d_side;
    logic              r_fv, d_v;
    logic [DATA_W-1:0] r_fma, r_fmb, d_q, d_rem;

    logic [DATA_W-1:0] lo, f_sbit, q_neg, n_res, r_res;
    logic              mneg, mbig, dneg;
    t_status           n_st, r_st;
    logic              r_ov;

    assign en         = !r_ov || o_out.ready;
    assign i_in.ready = en;

    always_comb begin
        act    = t_action'(i_in.action);
        sg     = i_in.signed_mode;
        mask   = width_mask(i_in.width_code);
        sbit   = mask ^ (mask >> 1);
        a      = i_in.operand_a & mask;
        b      = i_in.operand_b & mask;
        an     = sg && |(a & sbit);
        bn     = sg && |(b & sbit);
        bits   = 7'd8 << i_in.width_code;
        b_big  = b >= {57'd0, bits};
        sh     = b[5:0];
        sum    = (a + b) & mask;
        dif    = (a - b) & mask;
        xa     = sg ? (a ^ sbit) : a;
        xb     = sg ? (b ^ sbit) : b;
        shr_r  = ((a >> sh) | (an ? (mask & ~(mask >> sh)) : '0)) & mask;
        ma     = an ? ((~a + 64'd1) & mask) : a;
        mb     = bn ? ((~b + 64'd1) & mask) : b;
        pre_r  = '0;
        pre_st = ST_OK;
        case (act)
            ACT_ADD: begin
                pre_r = sum;
                if (!sg) begin
                    if (sum < a) pre_st = ST_OVF;
                end else if (an == bn && (|(sum & sbit)) != an) begin
                    pre_st = ST_OVF;
                end
            end
            ACT_SUB: begin
                pre_r = dif;
                if (!sg) begin
                    if (a < b) pre_st = ST_OVF;
                end else if (an != bn && (|(dif & sbit)) != an) begin
                    pre_st = ST_OVF;
                end
            end
            ACT_SHL: begin
                if (b_big) begin
                    pre_st = ST_SHIFT;
                end else begin
                    pre_r = (a << sh) & mask;
                end
            end
            ACT_SHR: begin
                if (b_big) begin
                    if (sg) begin
                        pre_r = an ? mask : '0;
                    end else begin
                        pre_st = ST_SHIFT;
                    end
                end else begin
                    pre_r = shr_r;
                end
            end
            ACT_LT:     pre_r = {63'd0, xa < xb};
            ACT_LE:     pre_r = {63'd0, xa <= xb};
            ACT_GT:     pre_r = {63'd0, xa > xb};
            ACT_GE:     pre_r = {63'd0, xa >= xb};
            ACT_EQ:     pre_r = {63'd0, a == b};
            ACT_NE:     pre_r = {63'd0, a != b};
            ACT_AND:    pre_r = a & b;
            ACT_OR:     pre_r = a | b;
            ACT_XOR:    pre_r = a ^ b;
            ACT_PLUS:   pre_r = a;
            ACT_NEG: begin
                pre_r = (~a + 64'd1) & mask;
                if (sg && a == sbit) pre_st = ST_OVF;
            end
            ACT_BITNOT: pre_r = ~a & mask;
            ACT_LOGNOT: pre_r = {63'd0, a == '0};
            default: begin
                pre_r  = '0;
                pre_st = ST_OK;
            end
        endcase
        n_ms = '{act: act, sg: sg, an: an, bn: bn, b_zero: (b == '0), mask: mask,
                 ma: ma, mb: mb, pre_r: pre_r, pre_st: pre_st};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_dv <= i_in.valid;
            r_fv <= m_v;
            r_ov <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ms  <= n_ms;
            r_ds  <= n_ds;
            r_fma <= m_side.ma;
            r_fmb <= m_side.mb;
            r_res <= n_res;
            r_st  <= n_st;
        end
    end

    mau_mul #(.SIDE_W($bits(t_mside))) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_dv),
        .i_ma    (r_ms.ma),
        .i_mb    (r_ms.mb),
        .i_side  (r_ms),
        .o_valid (m_v),
        .o_prod  (m_prod),
        .o_side  (m_side)
    );

    always_comb begin
        lo     = m_prod[DATA_W-1:0];
        f_sbit = m_side.mask ^ (m_side.mask >> 1);
        mneg   = m_side.an ^ m_side.bn;
        mbig   = (|m_prod[PROD_W-1:DATA_W]) || |(lo & ~m_side.mask);
        n_ds   = '{act: m_side.act, sg: m_side.sg, an: m_side.an, bn: m_side.bn,
                   b_zero: m_side.b_zero, mask: m_side.mask, pre_r: m_side.pre_r,
                   pre_st: m_side.pre_st};
        if (m_side.act == ACT_MUL) begin
            n_ds.pre_r  = (mneg ? (~lo + 64'd1) : lo) & m_side.mask;
            n_ds.pre_st = ST_OK;
            if (mbig || (m_side.sg && (mneg ? (lo > f_sbit) : (lo >= f_sbit)))) begin
                n_ds.pre_st = ST_OVF;
            end
        end
    end

    mau_div #(.SIDE_W($bits(t_dside))) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_fv),
        .i_dividend (r_fma),
        .i_divisor  (r_fmb),
        .i_side     (r_ds),
        .o_valid    (d_v),
        .o_quot     (d_q),
        .o_rem      (d_rem),
        .o_side     (d_side)
    );

    always_comb begin
        dneg  = d_side.an ^ d_side.bn;
        q_neg = d_side.mask ^ (d_side.mask >> 1);
        n_res = d_side.pre_r;
        n_st  = d_side.pre_st;
        if (d_side.act == ACT_DIV || d_side.act == ACT_MOD) begin
            if (d_side.b_zero) begin
                n_res = '0;
                n_st  = ST_DIV0;
            end else if (d_side.act == ACT_DIV) begin
                n_res = (dneg ? (~d_q + 64'd1) : d_q) & d_side.mask;
                n_st  = (d_side.sg && !dneg && d_q >= q_neg) ? ST_OVF : ST_OK;
            end else begin
                n_res = (d_side.an ? (~d_rem + 64'd1) : d_rem) & d_side.mask;
                n_st  = ST_OK;
            end
        end
    end

    assign o_out.valid  = r_ov;
    assign o_out.result = r_res;
    assign o_out.status = r_st;
endmodule

### sv/mau_chk.sv
// Port-level checker for the multi-width integer ALU, bound to the top level.
// Depends on mau_pkg for the status codes.
module mau_chk import mau_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_result,
    input logic [1:0]        i_status
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_result) && $stable(i_status))
        else $error("Output transaction changed while stalled.");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("Output valid after reset.");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("Input ready does not follow the output stall.");

    a_div0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_DIV0 || i_status == ST_SHIFT) |-> i_result == '0)
        else $error("Nonzero result with a divide or shift error.");
endmodule

bind multi_width_integer_alu mau_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_result    (o_out.result),
    .i_status    (o_out.status)
);
